>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro samples on posedge clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define IMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen.
`define IMM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/imm_pkg.sv
// Package for the integer matrix multiply block: beat types, codes, control structs.
// No dependencies.
`default_nettype none

package imm_pkg;

	// operation codes
	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	localparam logic [3:0] DIM_RESET = 4'd8;

	// multiply phases (32-bit slices of the operands)
	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	localparam int HALF_W = 32;

	typedef struct packed {
		logic [1:0]         operation;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] element;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic signed [31:0] product;
		logic               last;
	} out_beat_t;

	typedef struct packed {
		logic [3:0] rows_a;
		logic [3:0] inner_dim;
		logic [3:0] cols_b;
	} dims_t;

	// one multiply beat travelling down the MAC pipeline
	typedef struct packed {
		logic       valid;
		logic [1:0] phase;
		logic       first;  // clears the accumulator
		logic       emit;   // final beat of a dot product
		logic       last;   // final beat of the whole run
		logic [2:0] row;
		logic [2:0] col;
	} beat_ctl_t;

	typedef struct packed {
		logic advance;  // pipeline moves this cycle
		logic s2_busy;  // multiply stage holds a beat
	} mac_stat_t;

endpackage

`default_nettype wire

>>> sv/imm_store.sv
// Element store: one write port, one registered read port.
// Used for both matrix A and matrix B; no package dependency.
`default_nettype none

module imm_store #(
	parameter int DW    = 32,
	parameter int AW    = 6,
	parameter int DEPTH = 64
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/imm_mac.sv
// Shared multiply-accumulate unit: multiply stage, accumulator and result register.
// Depends on imm_pkg.
`default_nettype none

module imm_mac #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire imm_pkg::beat_ctl_t      ctl_s1,
	input  wire logic [DATA_WIDTH-1:0]   a_data,
	input  wire logic [DATA_WIDTH-1:0]   b_data,
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output imm_pkg::out_beat_t           out_data,
	output imm_pkg::mac_stat_t           stat
);

	import imm_pkg::*;

	localparam int MW = (DATA_WIDTH > HALF_W) ? HALF_W : DATA_WIDTH;

	logic [MW-1:0]         opx, opy;
	logic [MW-1:0]         a_lo, a_hi, b_lo, b_hi;
	logic [2*MW-1:0]       pp_s2;
	beat_ctl_t             ctl_s2;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] term, sum;
	logic [63:0]           sum_sx;
	logic                  advance;
	logic                  out_valid_q;
	out_beat_t             out_q;

	assign advance = !out_valid_q || out_ready;
	assign stat    = '{advance: advance, s2_busy: ctl_s2.valid};

	assign a_lo = MW'(a_data);
	assign b_lo = MW'(b_data);
	assign a_hi = MW'(a_data >> HALF_W);
	assign b_hi = MW'(b_data >> HALF_W);

	always_comb begin
		unique case (ctl_s1.phase)
			PH_LH:   begin opx = a_lo; opy = b_hi; end
			PH_HL:   begin opx = a_hi; opy = b_lo; end
			default: begin opx = a_lo; opy = b_lo; end
		endcase
	end

	// cross terms land at bit 32; they only exist for widths above 32
	always_comb begin
		if (ctl_s2.phase == PH_LL) begin
			term = DATA_WIDTH'(pp_s2);
		end else begin
			term = DATA_WIDTH'({pp_s2, HALF_W'(0)});
		end
		sum    = (ctl_s2.first ? '0 : acc_q) + term;
		sum_sx = 64'(signed'(sum));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				ctl_s2 <= ctl_s1;
			end
			if (advance && ctl_s2.valid && ctl_s2.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pp_s2 <= {MW'(0), opx} * {MW'(0), opy};
		end
		if (advance && ctl_s2.valid) begin
			acc_q <= sum;
			if (ctl_s2.emit) begin
				out_q.out_row <= ctl_s2.row;
				out_q.out_col <= ctl_s2.col;
				out_q.product <= sum_sx[31:0];
				out_q.last    <= ctl_s2.last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> sv/imm_seq.sv
// Sequencer: walks row, column, inner index and multiply phase, one beat per cycle while the MAC pipeline advances.
// Depends on imm_pkg.
`default_nettype none

module imm_seq #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire imm_pkg::dims_t     dims,
	input  wire imm_pkg::mac_stat_t stat,
	output logic                    idle,
	output logic [AW-1:0]           a_addr,
	output logic [AW-1:0]           b_addr,
	output imm_pkg::beat_ctl_t      ctl_s1
);

	import imm_pkg::*;

	localparam int         NPH      = (DATA_WIDTH > HALF_W) ? 3 : 1;
	localparam logic [1:0] PH_FINAL = 2'(NPH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN
	} state_t;

	state_t     state_q;
	logic [3:0] ra_q, kd_q, cb_q;
	logic [2:0] r_q, c_q, k_q;
	logic [1:0] ph_q;
	beat_ctl_t  ctl_s1_q;
	beat_ctl_t  issue;
	logic       last_ph, last_k, last_c, last_r;

	function automatic logic [3:0] clamp_dim(input logic [3:0] v);
		logic [3:0] res;
		res = v;
		if (v == 4'd0) begin
			res = 4'd1;
		end else if (v > 4'(MAX_DIM)) begin
			res = 4'(MAX_DIM);
		end
		return res;
	endfunction

	always_comb begin
		last_ph     = (ph_q == PH_FINAL);
		last_k      = (k_q == 3'(kd_q - 4'd1));
		last_c      = (c_q == 3'(cb_q - 4'd1));
		last_r      = (r_q == 3'(ra_q - 4'd1));
		issue.valid = (state_q == S_RUN);
		issue.phase = ph_q;
		issue.first = (k_q == 3'd0) && (ph_q == PH_LL);
		issue.emit  = last_ph && last_k;
		issue.last  = last_ph && last_k && last_c && last_r;
		issue.row   = r_q;
		issue.col   = c_q;
	end

	assign a_addr = AW'(7'(r_q) * 7'(MAX_DIM) + 7'(k_q));
	assign b_addr = AW'(7'(k_q) * 7'(MAX_DIM) + 7'(c_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ra_q     <= DIM_RESET;
			kd_q     <= DIM_RESET;
			cb_q     <= DIM_RESET;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			ph_q     <= PH_LL;
			ctl_s1_q <= '0;
		end else begin
			if (stat.advance) begin
				ctl_s1_q <= issue;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ra_q    <= clamp_dim(dims.rows_a);
						kd_q    <= clamp_dim(dims.inner_dim);
						cb_q    <= clamp_dim(dims.cols_b);
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						ph_q    <= PH_LL;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (stat.advance) begin
						if (!last_ph) begin
							ph_q <= ph_q + 2'd1;
						end else begin
							ph_q <= PH_LL;
							if (!last_k) begin
								k_q <= k_q + 3'd1;
							end else begin
								k_q <= '0;
								if (!last_c) begin
									c_q <= c_q + 3'd1;
								end else begin
									c_q <= '0;
									r_q <= r_q + 3'd1;
								end
							end
						end
						if (issue.last) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (!ctl_s1_q.valid && !stat.s2_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle   = (state_q == S_IDLE);
	assign ctl_s1 = ctl_s1_q;

endmodule

`default_nettype wire

>>> sv/integer_matrix_multiply.sv
// Integer matrix multiply, top level. Write items finish in the accept cycle.
// A compute item issues rows_a*cols_b*inner_dim multiply beats (x3 if DATA_WIDTH > 32),
// one per cycle through the single shared multiplier while out_ready does not stall the
// pipeline, followed by a pipeline drain; 512 beats at 8x8x8.
// Reset: dimension registers return to 8, sequencer and valid flags clear; the element
// stores are not cleared and hold garbage until written.
`default_nettype none

module integer_matrix_multiply #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [3:0]         cfg_data,
	// item input
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire imm_pkg::in_beat_t  in_data,
	// result output
	output logic                    out_valid,
	input  wire logic               out_ready,
	output imm_pkg::out_beat_t      out_data
);

	import imm_pkg::*;

	// Store layout: element (row, col) lives at row*MAX_DIM + col.
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

	dims_t                 dims_q;
	logic                  seq_idle;
	logic                  in_fire;
	logic                  in_range;
	logic                  start;
	logic                  we_a, we_b;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         a_addr, b_addr;
	logic [DATA_WIDTH-1:0] a_data, b_data;
	beat_ctl_t             ctl_s1;
	mac_stat_t             stat;

	// ------------------------------------------------------------------
	// Configuration registers. Raw values are kept; the sequencer clamps
	// them to 1..MAX_DIM when a compute beat starts. Index 3 is dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= '{rows_a: DIM_RESET, inner_dim: DIM_RESET, cols_b: DIM_RESET};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROWS_A:    dims_q.rows_a    <= cfg_data;
				REG_INNER_DIM: dims_q.inner_dim <= cfg_data;
				REG_COLS_B:    dims_q.cols_b    <= cfg_data;
				default:       ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input decode. The block takes a beat only while the sequencer is idle.
	// Element writes finish in the accept cycle; writes that fall outside
	// the MAX_DIM x MAX_DIM store are dropped. Operation 3 is swallowed.
	// ------------------------------------------------------------------
	assign in_ready = seq_idle;
	assign in_fire  = in_valid && in_ready;
	assign in_range = ({1'b0, in_data.row} < 4'(MAX_DIM)) && ({1'b0, in_data.col} < 4'(MAX_DIM));
	assign we_a     = in_fire && in_range && (in_data.operation == OP_WRITE_A);
	assign we_b     = in_fire && in_range && (in_data.operation == OP_WRITE_B);
	assign start    = in_fire && (in_data.operation == OP_COMPUTE);
	assign waddr    = AW'(7'(in_data.row) * 7'(MAX_DIM) + 7'(in_data.col));
	// sign-extend (or trim) the 32-bit element to the storage width
	assign wdata    = DATA_WIDTH'(64'(in_data.element));

	// ------------------------------------------------------------------
	// Element stores. Reads are registered and move with the pipeline, so
	// the read data lines up with ctl_s1 out of the sequencer.
	// ------------------------------------------------------------------
	imm_store #(
		.DW    (DATA_WIDTH),
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (stat.advance),
		.raddr (a_addr),
		.rdata (a_data)
	);

	imm_store #(
		.DW    (DATA_WIDTH),
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (stat.advance),
		.raddr (b_addr),
		.rdata (b_data)
	);

	// ------------------------------------------------------------------
	// Sequencer: row-major over the product, inner index innermost, and
	// for wide data three 32x32 partial products per inner step.
	// ------------------------------------------------------------------
	imm_seq #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.dims   (dims_q),
		.stat   (stat),
		.idle   (seq_idle),
		.a_addr (a_addr),
		.b_addr (b_addr),
		.ctl_s1 (ctl_s1)
	);

	// ------------------------------------------------------------------
	// Shared MAC. The whole pipeline freezes while a result beat sits in
	// the output register and out_ready is low.
	// ------------------------------------------------------------------
	imm_mac #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.a_data    (a_data),
		.b_data    (b_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (stat)
	);

endmodule

`default_nettype wire

>>> sv/imm_checker.sv
// Port-level checker for integer_matrix_multiply, bound to the top level.
// Depends on imm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module imm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire imm_pkg::in_beat_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire imm_pkg::out_beat_t out_data
);

	import imm_pkg::*;

	// a stalled result beat holds
	`IMM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while stalled")

	// a compute beat makes the block busy
	`IMM_ASSERT(a_busy_after_compute, in_valid && in_ready && in_data.operation == OP_COMPUTE |=> !in_ready, "ready after compute")

	// with results of a run still to come the block takes no input
	`IMM_NEVER(a_idle_mid_run, out_valid && !out_data.last && in_ready, "ready before the last result")

	// element writes produce no result
	`IMM_ASSERT(a_write_silent, in_valid && in_ready && !out_valid && (in_data.operation == OP_WRITE_A || in_data.operation == OP_WRITE_B) |=> !out_valid, "result after an element write")

	// nothing follows the last result of a run
	`IMM_ASSERT(a_last_ends_run, out_valid && out_ready && out_data.last |=> !out_valid, "result after the last one")

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);

`default_nettype wire
